// ===== sv/tqtm_pkg.sv =====
// package for the task queue, timer and mutex engine
// holds command codes, table sizes and fixed field widths; no dependencies
package tqtm_pkg;

  localparam int NUM_TASKS    = 16;
  localparam int NUM_QUEUES   = 4;
  localparam int NUM_TIMERS   = 8;
  localparam int NUM_SECTIONS = 4;

  localparam int TIME_W = 27;
  localparam int DL_W = TIME_W + 1;
  localparam int CMD_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_QINIT  = 4'd0,
    CMD_QADD   = 4'd1,
    CMD_QPOP   = 4'd2,
    CMD_QEMPTY = 4'd3,
    CMD_TSTART = 4'd4,
    CMD_TSTOP  = 4'd5,
    CMD_SINIT  = 4'd6,
    CMD_ENTER  = 4'd7,
    CMD_LEAVE  = 4'd8,
    CMD_TICK   = 4'd9,
    CMD_TINIT  = 4'd10
  } cmd_t;

endpackage

// ===== sv/task_queue_timer_mutex_engine_core.sv =====
// top level of the task queue, timer and mutex engine
// depends on tqtm_pkg
//
// usage: one input channel (valid/stall) carries commands, one output channel
// (out_valid/out_stall) returns exactly one result item per command.
// a small sequencer runs each command in steps: decode and read, queue or
// section work, and for a tick a scan of the timers one per cycle that pauses
// for a queue add on each expired timer; then the result is held in an output
// register.
// the block takes a new item only when the result register is empty, so
// a stalled receiver holds the result and the input stays stalled.
// main_queue is written by cfg_we/cfg_data at any edge.
// reset (rst, synchronous) empties all queues, stops all timers, frees all
// sections, clears the time counter and main_queue; the link table
// is cleared by reset at once (flip-flops).
module task_queue_timer_mutex_engine_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tqtm_pkg::CMD_W-1:0]  command,
  input  logic [1:0]                  queue_index,
  input  logic [4:0]                  task_index,
  input  logic [2:0]                  timer_index,
  input  logic [1:0]                  section_index,
  input  logic [tqtm_pkg::TIME_W-1:0] delay,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  popped_task,
  output logic                        queue_is_empty,
  output logic                        granted,
  output logic [3:0]                  fired_count
);
  import tqtm_pkg::*;

  localparam logic [4:0] NO_TASK = 5'(NUM_TASKS);
  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int KW = $clog2(NUM_TASKS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_POP  = 6'b000100,
    S_ADD  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t after_add;

  logic [1:0]  main_queue;
  logic [4:0]  next_link [NUM_TASKS];
  logic [4:0]  queue_head [4];
  logic [4:0]  queue_tail [4];
  logic [DL_W-1:0] timer_deadline [NUM_TIMERS];
  logic [4:0]  timer_task [NUM_TIMERS];
  logic [1:0]  section_queue [4];
  logic [4:0]  section_owner [4];
  logic [DL_W-1:0] current_time;

  cmd_t        cmd;
  logic [1:0]  q_r;
  logic [4:0]  task_r;
  logic [2:0]  tmr_r;
  logic [1:0]  sec_r;
  logic [TIME_W-1:0] delay_r;

  // shared queue-add request
  logic [2:0]  add_q;   // bit 2 set: queue out of range
  logic [4:0]  add_t;
  logic [2:0]  pop_q;
  logic [TW:0] scan_idx;
  logic        leave_pop;

  logic [4:0]  r_popped;
  logic        r_empty;
  logic        r_granted;
  logic [3:0]  r_fired;

  function automatic logic [4:0] norm(input logic [4:0] t);
    return (t < NO_TASK) ? t : NO_TASK;
  endfunction

  function automatic logic q_out(input logic [1:0] q);
    return (32'(q) >= NUM_QUEUES);
  endfunction

  function automatic logic [2:0] qsel(input logic [1:0] q);
    return {q_out(q), q};
  endfunction

  logic [DL_W-1:0] sum;
  assign sum = current_time + DL_W'(delay_r) - DL_W'(1);

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign popped_task = r_popped;
  assign queue_is_empty = r_empty;
  assign granted = r_granted;
  assign fired_count = r_fired;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      main_queue <= '0;
      current_time <= '0;
      for (int i = 0; i < NUM_TASKS; i++) next_link[i] <= NO_TASK;
      for (int i = 0; i < 4; i++) begin
        queue_head[i] <= NO_TASK;
        queue_tail[i] <= NO_TASK;
        section_queue[i] <= '0;
        section_owner[i] <= NO_TASK;
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_deadline[i] <= '0;
        timer_task[i] <= NO_TASK;
      end
    end else begin
      if (cfg_we) main_queue <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= cmd_t'(command);
            q_r <= queue_index;
            task_r <= norm(task_index);
            tmr_r <= timer_index;
            sec_r <= section_index;
            delay_r <= delay;
            r_popped <= NO_TASK;
            r_empty <= 1'b0;
            r_granted <= 1'b0;
            r_fired <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd)
            CMD_QINIT: begin
              if (!q_out(q_r)) begin
                queue_head[q_r] <= NO_TASK;
                queue_tail[q_r] <= NO_TASK;
              end
              state <= S_DONE;
            end
            CMD_QADD: begin
              add_q <= qsel(q_r);
              add_t <= task_r;
              after_add <= S_DONE;
              state <= S_ADD;
            end
            CMD_QPOP: begin
              pop_q <= qsel(q_r);
              leave_pop <= 1'b0;
              state <= S_POP;
            end
            CMD_QEMPTY: begin
              r_empty <= q_out(q_r) || (queue_head[q_r] >= NO_TASK);
              state <= S_DONE;
            end
            CMD_TSTART: begin
              if (32'(tmr_r) < NUM_TIMERS) begin
                timer_deadline[TW'(tmr_r)] <= {1'b0, sum[TIME_W-1:0]} + DL_W'(1);
                timer_task[TW'(tmr_r)] <= task_r;
              end
              state <= S_DONE;
            end
            CMD_TSTOP: begin
              if (32'(tmr_r) < NUM_TIMERS) timer_deadline[TW'(tmr_r)] <= '0;
              state <= S_DONE;
            end
            CMD_SINIT: begin
              if (32'(sec_r) < NUM_SECTIONS) begin
                if (!q_out(q_r)) begin
                  queue_head[q_r] <= NO_TASK;
                  queue_tail[q_r] <= NO_TASK;
                end
                section_queue[sec_r] <= q_r;
                section_owner[sec_r] <= NO_TASK;
              end
              state <= S_DONE;
            end
            CMD_ENTER: begin
              if (32'(sec_r) < NUM_SECTIONS && section_owner[sec_r] < NO_TASK) begin
                add_q <= qsel(section_queue[sec_r]);
                add_t <= task_r;
                after_add <= S_DONE;
                state <= S_ADD;
              end else begin
                if (32'(sec_r) < NUM_SECTIONS) begin
                  section_owner[sec_r] <= task_r;
                  r_granted <= 1'b1;
                end
                state <= S_DONE;
              end
            end
            CMD_LEAVE: begin
              if (32'(sec_r) < NUM_SECTIONS) begin
                pop_q <= qsel(section_queue[sec_r]);
                leave_pop <= 1'b1;
                state <= S_POP;
              end else begin
                state <= S_DONE;
              end
            end
            CMD_TICK: begin
              current_time <= {1'b0, current_time[TIME_W-1:0]} + DL_W'(1);
              scan_idx <= '0;
              state <= S_SCAN;
            end
            CMD_TINIT: begin
              if (task_r < NO_TASK) next_link[KW'(task_r)] <= NO_TASK;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_POP: begin
          logic [4:0] t;
          t = pop_q[2] ? NO_TASK : queue_head[pop_q[1:0]];
          if (t < NO_TASK) begin
            queue_head[pop_q[1:0]] <= norm(next_link[KW'(t)]);
            next_link[KW'(t)] <= NO_TASK;
          end else begin
            t = NO_TASK;
          end
          if (leave_pop) begin
            section_owner[sec_r] <= t;
            add_q <= qsel(main_queue);
            add_t <= t;
            after_add <= S_DONE;
            state <= S_ADD;
          end else begin
            r_popped <= t;
            state <= S_DONE;
          end
        end
        S_ADD: begin
          if (!add_q[2] && add_t < NO_TASK) begin
            if (queue_head[add_q[1:0]] >= NO_TASK)
              queue_head[add_q[1:0]] <= add_t;
            else if (queue_tail[add_q[1:0]] < NO_TASK)
              next_link[KW'(queue_tail[add_q[1:0]])] <= add_t;
            queue_tail[add_q[1:0]] <= add_t;
          end
          state <= after_add;
        end
        S_SCAN: begin
          if (32'(scan_idx) >= NUM_TIMERS) begin
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            if (timer_deadline[TW'(scan_idx)] == current_time) begin
              timer_deadline[TW'(scan_idx)] <= '0;
              r_fired <= r_fired + 4'd1;
              add_q <= qsel(main_queue);
              add_t <= timer_task[TW'(scan_idx)];
              after_add <= S_SCAN;
              state <= S_ADD;
            end
          end
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
